// File: src/pfva_pkg.sv
// ----------------------------------------------------------------------------
// pfva_pkg
// Types, constants and helpers for the pair force velocity accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfva_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 48;   // wrapped offset width
	localparam int PW        = 66;   // product width

	localparam logic [2:0] REG_WORLD_WIDTH  = 3'd0;
	localparam logic [2:0] REG_WORLD_HEIGHT = 3'd1;
	localparam logic [2:0] REG_REPEL_DIST   = 3'd2;
	localparam logic [2:0] REG_FORCE_DIST   = 3'd3;
	localparam logic [2:0] REG_REPEL_STR    = 3'd4;
	localparam logic [2:0] REG_TIME_STEP    = 3'd5;
	localparam logic [2:0] REG_MAX_INTER    = 3'd6;

	typedef struct packed {
		logic               start_group;
		logic [31:0]        self_x;
		logic [31:0]        self_y;
		logic signed [31:0] self_vx;
		logic signed [31:0] self_vy;
		logic [31:0]        other_x;
		logic [31:0]        other_y;
		logic               same_particle;
		logic signed [31:0] pair_strength;
		logic               last_pair;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] new_vx;
		logic signed [31:0] new_vy;
		logic [8:0]         interaction_total;
	} result_t;

	typedef enum logic [1:0] {
		OP_DIV  = 2'b01,
		OP_SQRT = 2'b10
	} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [63:0] num;
		logic [31:0] den;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] q;
		logic        ovf;
	} unit_rsp_t;

	function automatic logic signed [DW-1:0] wrap(input logic signed [DW-1:0] d,
		input logic [15:0] units);
		logic signed [DW-1:0] lim;
		logic signed [DW-1:0] half;
		logic signed [DW-1:0] t;
		lim  = $signed(DW'(units) << FRAC_BITS);
		half = $signed(DW'(units >> 1) << FRAC_BITS);
		t    = (d > half) ? d - lim : d;
		t    = (t < -half) ? t + lim : t;
		return t;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(32'sh7fffffff);
		lo = -PW'(64'sh80000000);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [PW-1:0] sdiv_frac(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] bias;
		bias = v[PW-1] ? $signed((PW'(1) << FRAC_BITS) - PW'(1)) : '0;
		return (v + bias) >>> FRAC_BITS;
	endfunction

	function automatic logic [63:0] mag(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] a;
		a = v[PW-1] ? -v : v;
		return a[63:0];
	endfunction

	function automatic logic signed [31:0] sat_q(input logic neg, input logic [31:0] q,
		input logic ovf);
		if (!neg) begin
			return (ovf || q[31]) ? 32'sh7fffffff : $signed(q);
		end
		if (ovf || (q[31] && |q[30:0])) begin
			return 32'sh80000000;
		end
		return $signed(-q);
	endfunction

endpackage

`default_nettype wire

// File: src/pfva_iter_unit.sv
// ----------------------------------------------------------------------------
// pfva_iter_unit
// Shared radix-2 divider / radix-4 square root, one compare-subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfva_iter_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfva_pkg::unit_req_t req,
	output      pfva_pkg::unit_rsp_t rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic        sqrt_q;
	logic [34:0] rem_q;
	logic [63:0] sh_q;
	logic [31:0] den_q;
	logic [31:0] q_q;
	logic        ovf_q;
	logic        done_q;

	logic [34:0] cand;
	logic [34:0] trial;
	logic        ge;

	always_comb begin
		if (sqrt_q) begin
			cand  = {rem_q[32:0], sh_q[63:62]};
			trial = {1'b0, q_q, 2'b01};
		end else begin
			cand  = {2'b00, rem_q[31:0], sh_q[63]};
			trial = {3'b000, den_q};
		end
		ge = cand >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= (req.op == pfva_pkg::OP_SQRT);
			den_q  <= req.den;
			q_q    <= '0;
			if (req.op == pfva_pkg::OP_SQRT) begin
				rem_q <= '0;
				sh_q  <= req.num;
				ovf_q <= 1'b0;
			end else begin
				rem_q <= {3'b000, req.num[63:32]};
				sh_q  <= {req.num[31:0], 32'b0};
				ovf_q <= req.num[63:32] >= req.den;
			end
		end else if (busy_q) begin
			rem_q <= ge ? cand - trial : cand;
			q_q   <= {q_q[30:0], ge};
			sh_q  <= sqrt_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;
	assign rsp.ovf  = ovf_q;

endmodule

`default_nettype wire

// File: src/pair_force_velocity_accumulator_unit.sv
// ----------------------------------------------------------------------------
// pair_force_velocity_accumulator_unit
// Accumulates particle-life pair forces onto a particle velocity, Q16.16.
//
//   channel   dir  handshake             payload
//   pair      in   pair_valid/ready      pfva_pkg::pair_t
//   result    out  result_valid/ready    pfva_pkg::result_t
//   cfg       in   cfg_we (no stall)     cfg_index, cfg_data
//
// pair_ready drops after an accepted pair; a skipped pair, a far offset, no force
// applied, the force band and the repel band each take a different state path.
// Each sqrt or divide runs on the shared 32-step serial unit.
// Reset clears velocity and count. pair_ready is low while a pair is in work;
// a held result stalls only the final pair of the next group.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_force_velocity_accumulator_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pair_valid,
	output      logic              pair_ready,
	input  wire pfva_pkg::pair_t   pair,
	output      logic              result_valid,
	input  wire logic              result_ready,
	output      pfva_pkg::result_t result,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_WRAP  = 17'h00002,
		ST_MSQX  = 17'h00004,
		ST_MSQY  = 17'h00008,
		ST_MRSQ  = 17'h00010,
		ST_MFSQ  = 17'h00020,
		ST_SQS   = 17'h00040,
		ST_SQW   = 17'h00080,
		ST_CLASS = 17'h00100,
		ST_FNUM  = 17'h00200,
		ST_FDW   = 17'h00400,
		ST_PM    = 17'h00800,
		ST_PS    = 17'h01000,
		ST_PW    = 17'h02000,
		ST_PT    = 17'h04000,
		ST_PA    = 17'h08000,
		ST_FIN   = 17'h10000
	} state_t;

	state_t state_q;

	logic [15:0]        width_q;
	logic [15:0]        height_q;
	logic [23:0]        repel_q;
	logic [23:0]        force_q;
	logic signed [31:0] rstr_q;
	logic [16:0]        dt_q;
	logic [7:0]         maxi_q;

	logic signed [31:0] acc_vx_q;
	logic signed [31:0] acc_vy_q;
	logic [8:0]         cnt_q;

	logic signed [pfva_pkg::DW-1:0] dx_q;
	logic signed [pfva_pkg::DW-1:0] dy_q;
	logic signed [31:0] ps_q;
	logic               last_q;
	logic [63:0]        dr_q;
	logic [47:0]        rsq_q;
	logic [47:0]        fsq_q;
	logic [31:0]        r_q;
	logic               rep_q;
	logic               neg_q;
	logic               axis_q;
	logic signed [31:0] f_q;
	logic signed [31:0] fc_q;

	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [pfva_pkg::PW-1:0] mul_q;

	pfva_pkg::unit_req_t req;
	pfva_pkg::unit_rsp_t rsp;

	logic        accept;
	logic        active;
	logic        far;
	logic        rep;
	logic        frc;
	logic signed [32:0] dxs;
	logic signed [32:0] dys;
	logic signed [32:0] rep_m_r;
	logic signed [pfva_pkg::PW-1:0] acc_sel;
	logic signed [pfva_pkg::PW-1:0] acc_sum;
	logic        res_free;

	pfva_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign pair_ready = (state_q == ST_IDLE);
	assign accept     = pair_valid && pair_ready;
	assign active     = ((pair.start_group ? 9'd0 : cnt_q) <= {1'b0, maxi_q})
		&& !pair.same_particle;

	localparam logic signed [pfva_pkg::DW-1:0] LIM30 = pfva_pkg::DW'(1) << 30;

	assign far = (dx_q >= LIM30) || (dx_q <= -LIM30) || (dy_q >= LIM30) || (dy_q <= -LIM30);
	assign dxs = 33'(dx_q);
	assign dys = 33'(dy_q);
	assign rep_m_r = $signed({9'b0, repel_q}) - $signed({1'b0, r_q});
	assign rep = (dr_q != 64'd0) && (dr_q < 64'(rsq_q));
	assign frc = (dr_q > 64'(rsq_q)) && (dr_q < 64'(fsq_q));
	assign acc_sel = axis_q ? pfva_pkg::PW'(acc_vy_q) : pfva_pkg::PW'(acc_vx_q);
	assign acc_sum = acc_sel + pfva_pkg::sdiv_frac(mul_q);
	assign res_free = !result_valid || result_ready;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_MSQX: begin
				ma = dxs;
				mb = dxs;
			end
			ST_MSQY: begin
				ma = dys;
				mb = dys;
			end
			ST_MRSQ: begin
				ma = $signed({9'b0, repel_q});
				mb = $signed({9'b0, repel_q});
			end
			ST_MFSQ: begin
				ma = $signed({9'b0, force_q});
				mb = $signed({9'b0, force_q});
			end
			ST_CLASS: begin
				if (rep) begin
					ma = 33'(rstr_q);
					mb = rep_m_r;
				end else begin
					ma = 33'(ps_q);
					mb = -rep_m_r;
				end
			end
			ST_PM: begin
				ma = 33'(f_q);
				mb = axis_q ? dys : dxs;
			end
			ST_PT: begin
				ma = 33'(fc_q);
				mb = $signed({16'b0, dt_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		req.start = 1'b0;
		req.op    = pfva_pkg::OP_DIV;
		req.num   = pfva_pkg::mag(mul_q);
		req.den   = r_q;
		case (state_q)
			ST_SQS: begin
				req.start = 1'b1;
				req.op    = pfva_pkg::OP_SQRT;
				req.num   = dr_q;
			end
			ST_FNUM: begin
				req.start = rep_q;
				req.den   = r_q + (32'd1 << pfva_pkg::FRAC_BITS);
			end
			ST_PS: begin
				req.start = 1'b1;
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd1024;
			height_q <= 16'd1024;
			repel_q  <= 24'd655360;
			force_q  <= 24'd3276800;
			rstr_q   <= 32'sd65536;
			dt_q     <= 17'd6554;
			maxi_q   <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				pfva_pkg::REG_WORLD_WIDTH:  width_q  <= cfg_data[15:0];
				pfva_pkg::REG_WORLD_HEIGHT: height_q <= cfg_data[15:0];
				pfva_pkg::REG_REPEL_DIST:   repel_q  <= cfg_data[23:0];
				pfva_pkg::REG_FORCE_DIST:   force_q  <= cfg_data[23:0];
				pfva_pkg::REG_REPEL_STR:    rstr_q   <= $signed(cfg_data);
				pfva_pkg::REG_TIME_STEP:    dt_q     <= cfg_data[16:0];
				pfva_pkg::REG_MAX_INTER:    maxi_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			acc_vx_q     <= '0;
			acc_vy_q     <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
			axis_q       <= 1'b0;
		end else begin
			if (result_valid && result_ready && !(state_q == ST_FIN && last_q)) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pair.start_group) begin
							acc_vx_q <= pair.self_vx;
							acc_vy_q <= pair.self_vy;
							cnt_q    <= '0;
						end
						state_q <= active ? ST_WRAP : ST_FIN;
					end
				end
				ST_WRAP:  state_q <= ST_MSQX;
				ST_MSQX:  state_q <= far ? ST_FIN : ST_MSQY;
				ST_MSQY:  state_q <= ST_MRSQ;
				ST_MRSQ:  state_q <= ST_MFSQ;
				ST_MFSQ:  state_q <= ST_SQS;
				ST_SQS:   state_q <= ST_SQW;
				ST_SQW: begin
					if (rsp.done) begin
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: state_q <= (rep || frc) ? ST_FNUM : ST_FIN;
				ST_FNUM: begin
					axis_q  <= 1'b0;
					state_q <= rep_q ? ST_FDW : ST_PM;
				end
				ST_FDW: begin
					if (rsp.done) begin
						state_q <= ST_PM;
					end
				end
				ST_PM:    state_q <= ST_PS;
				ST_PS:    state_q <= ST_PW;
				ST_PW: begin
					if (rsp.done) begin
						state_q <= ST_PT;
					end
				end
				ST_PT:    state_q <= ST_PA;
				ST_PA: begin
					if (axis_q) begin
						acc_vy_q <= pfva_pkg::sat32(acc_sum);
						cnt_q    <= cnt_q + 9'd1;
						state_q  <= ST_FIN;
					end else begin
						acc_vx_q <= pfva_pkg::sat32(acc_sum);
						axis_q   <= 1'b1;
						state_q  <= ST_PM;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (res_free) begin
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q   <= pfva_pkg::DW'($signed({1'b0, pair.self_x}) - $signed({1'b0, pair.other_x}));
			dy_q   <= pfva_pkg::DW'($signed({1'b0, pair.self_y}) - $signed({1'b0, pair.other_y}));
			ps_q   <= pair.pair_strength;
			last_q <= pair.last_pair;
		end
		case (state_q)
			ST_WRAP: begin
				dx_q <= pfva_pkg::wrap(dx_q, width_q);
				dy_q <= pfva_pkg::wrap(dy_q, height_q);
			end
			ST_MSQY:  dr_q  <= mul_q[63:0];
			ST_MRSQ:  dr_q  <= dr_q + mul_q[63:0];
			ST_MFSQ:  rsq_q <= mul_q[47:0];
			ST_SQS:   fsq_q <= mul_q[47:0];
			ST_SQW: begin
				if (rsp.done) begin
					r_q <= rsp.q;
				end
			end
			ST_CLASS: rep_q <= rep;
			ST_FNUM: begin
				neg_q <= mul_q[pfva_pkg::PW-1];
				if (!rep_q) begin
					f_q <= pfva_pkg::sat32(pfva_pkg::sdiv_frac(mul_q));
				end
			end
			ST_FDW: begin
				if (rsp.done) begin
					f_q <= pfva_pkg::sat_q(neg_q, rsp.q, rsp.ovf);
				end
			end
			ST_PS:    neg_q <= mul_q[pfva_pkg::PW-1];
			ST_PW: begin
				if (rsp.done) begin
					fc_q <= pfva_pkg::sat_q(neg_q, rsp.q, rsp.ovf);
				end
			end
			ST_FIN: begin
				if (last_q && res_free) begin
					result.new_vx            <= acc_vx_q;
					result.new_vy            <= acc_vy_q;
					result.interaction_total <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_SQW || state_q == ST_FDW || state_q == ST_PW))
		else $error("iter unit done outside a wait state");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 9'd256)
		else $error("interaction count out of range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q && res_free) |=> result_valid)
		else $error("final transaction produced no result");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_PA) |=> $stable(cnt_q))
		else $error("count changed outside accumulate");

endmodule

`default_nettype wire
